/* src/cpu8_operand_address_resolver_defines.svh */
// Assertion macros shared by the operand address resolver checkers.
`ifndef CPU8_OPERAND_ADDRESS_RESOLVER_DEFINES_SVH
`define CPU8_OPERAND_ADDRESS_RESOLVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPU8OAR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("operand resolver check failed");

// The signal must keep its value in the cycle after the condition.
`define CPU8OAR_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("operand resolver payload changed while stalled");

`endif

/* src/cpu8oar_pkg.sv */
// Types and constants of the 8-bit CPU operand address resolver.
`default_nettype none

package cpu8oar_pkg;

    localparam int AddrBits = 16;
    localparam int DataBits = 8;

    localparam logic ACT_BEGIN  = 1'b0;
    localparam logic ACT_DATA   = 1'b1;
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef enum logic [3:0] {
        M_IMPLICIT    = 4'd0,
        M_ACCUMULATOR = 4'd1,
        M_IMMEDIATE   = 4'd2,
        M_ZP          = 4'd3,
        M_ZPX         = 4'd4,
        M_ZPY         = 4'd5,
        M_REL         = 4'd6,
        M_ABS         = 4'd7,
        M_ABSX        = 4'd8,
        M_ABSY        = 4'd9,
        M_IND         = 4'd10,
        M_IZX         = 4'd11,
        M_IZY         = 4'd12
    } t_mode;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_OP1   = 5'b00010,
        PH_OP2   = 5'b00100,
        PH_PTRLO = 5'b01000,
        PH_PTRHI = 5'b10000
    } t_phase;

    typedef struct packed {
        logic                action;
        logic [3:0]          mode;
        logic                may_add_cycle;
        logic [DataBits-1:0] index_x;
        logic [DataBits-1:0] index_y;
        logic [AddrBits-1:0] program_counter;
        logic [DataBits-1:0] read_data;
    } t_item;

    typedef struct packed {
        logic                kind;
        logic [AddrBits-1:0] read_address;
        logic [AddrBits-1:0] operand_value;
        logic                page_crossed;
        logic [AddrBits-1:0] next_pc;
    } t_result;

endpackage

`default_nettype wire

/* src/cpu8_operand_address_resolver.sv */
// Top level of the 8-bit CPU operand address resolver: input and result registers.
//
// Channel  Direction  Handshake                Payload
// in       input      i_in_valid / o_in_ready  action, mode, flags, X, Y, PC, read data
// out      output     o_out_valid / i_out_ready kind, read address, operand, crossed, PC
//
// Each input beat is registered and stepped once the output register can take its
// result, which lands there; one beat per clock is sustained while the output is not stalled.
// A begin beat or a read-data beat yields at most one result; read data while idle
// yields none. Reset is synchronous and clears the valid flags and the sequencer state.
// A stalled output register holds the pending beat in the input register.
`default_nettype none

module cpu8_operand_address_resolver (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_action,
    input  wire  [3:0]  i_mode,
    input  wire         i_may_add_cycle,
    input  wire  [7:0]  i_index_x,
    input  wire  [7:0]  i_index_y,
    input  wire  [15:0] i_program_counter,
    input  wire  [7:0]  i_read_data,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_kind,
    output logic [15:0] o_read_address,
    output logic [15:0] o_operand_value,
    output logic        o_page_crossed,
    output logic [15:0] o_next_pc
);

    logic                 r_in_valid;
    cpu8oar_pkg::t_item   r_item;
    logic                 r_out_valid;
    cpu8oar_pkg::t_result r_res;
    logic                 w_adv;
    logic                 w_accept;
    logic                 w_emit;
    cpu8oar_pkg::t_result w_res;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    cpu8oar_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_adv),
        .i_item   (r_item),
        .o_emit   (w_emit),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.action          <= i_action;
            r_item.mode            <= i_mode;
            r_item.may_add_cycle   <= i_may_add_cycle;
            r_item.index_x         <= i_index_x;
            r_item.index_y         <= i_index_y;
            r_item.program_counter <= i_program_counter;
            r_item.read_data       <= i_read_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_res.kind;
    assign o_read_address  = r_res.read_address;
    assign o_operand_value = r_res.operand_value;
    assign o_page_crossed  = r_res.page_crossed;
    assign o_next_pc       = r_res.next_pc;

endmodule

`default_nettype wire

/* src/cpu8oar_core.sv */
// Addressing-mode sequencer: held instruction state and the per-beat step logic.
`default_nettype none

module cpu8oar_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_go,
    input  wire cpu8oar_pkg::t_item i_item,
    output logic                  o_emit,
    output cpu8oar_pkg::t_result  o_result
);

    cpu8oar_pkg::t_phase r_phase, n_phase;
    cpu8oar_pkg::t_mode  r_mode, n_mode;
    logic                r_cross_en, n_cross_en;
    logic [cpu8oar_pkg::DataBits-1:0] r_x, n_x;
    logic [cpu8oar_pkg::DataBits-1:0] r_y, n_y;
    logic [cpu8oar_pkg::AddrBits-1:0] r_pc, n_pc;
    logic [cpu8oar_pkg::DataBits-1:0] r_first, n_first;
    logic [cpu8oar_pkg::AddrBits-1:0] r_ptr, n_ptr;

    cpu8oar_pkg::t_mode               w_in_mode;
    logic [cpu8oar_pkg::DataBits-1:0] w_b;
    logic [cpu8oar_pkg::AddrBits-1:0] w_word;
    logic [cpu8oar_pkg::DataBits-1:0] w_zp_x;
    logic [cpu8oar_pkg::DataBits-1:0] w_zp_y;
    logic [cpu8oar_pkg::AddrBits-1:0] w_sum_x;
    logic [cpu8oar_pkg::AddrBits-1:0] w_sum_y;
    logic                             w_cross_x;
    logic                             w_cross_y;

    function automatic cpu8oar_pkg::t_result mk_read(
        input logic [cpu8oar_pkg::AddrBits-1:0] addr
    );
        cpu8oar_pkg::t_result res;
        res              = '0;
        res.kind         = cpu8oar_pkg::KIND_READ;
        res.read_address = addr;
        return res;
    endfunction

    function automatic cpu8oar_pkg::t_result mk_final(
        input logic [cpu8oar_pkg::AddrBits-1:0] value,
        input logic                             crossed,
        input logic [cpu8oar_pkg::AddrBits-1:0] npc
    );
        cpu8oar_pkg::t_result res;
        res               = '0;
        res.kind          = cpu8oar_pkg::KIND_FINAL;
        res.operand_value = value;
        res.page_crossed  = crossed;
        res.next_pc       = npc;
        return res;
    endfunction

    assign w_in_mode = cpu8oar_pkg::t_mode'(i_item.mode);
    assign w_b       = i_item.read_data;
    assign w_word    = {w_b, r_first};
    assign w_zp_x    = w_b + r_x;
    assign w_zp_y    = w_b + r_y;
    assign w_sum_x   = w_word + {{(cpu8oar_pkg::AddrBits-cpu8oar_pkg::DataBits){1'b0}}, r_x};
    assign w_sum_y   = w_word + {{(cpu8oar_pkg::AddrBits-cpu8oar_pkg::DataBits){1'b0}}, r_y};
    assign w_cross_x = r_cross_en && (w_word[15:8] != w_sum_x[15:8]);
    assign w_cross_y = r_cross_en && (w_word[15:8] != w_sum_y[15:8]);

    always_comb begin
        n_phase    = r_phase;
        n_mode     = r_mode;
        n_cross_en = r_cross_en;
        n_x        = r_x;
        n_y        = r_y;
        n_pc       = r_pc;
        n_first    = r_first;
        n_ptr      = r_ptr;
        o_emit     = 1'b0;
        o_result   = '0;
        if (i_go) begin
            if (i_item.action == cpu8oar_pkg::ACT_BEGIN) begin
                n_mode     = w_in_mode;
                n_cross_en = i_item.may_add_cycle;
                n_x        = i_item.index_x;
                n_y        = i_item.index_y;
                o_emit     = 1'b1;
                if (i_item.mode < cpu8oar_pkg::M_IMMEDIATE ||
                        i_item.mode > cpu8oar_pkg::M_IZY) begin
                    n_pc     = i_item.program_counter;
                    n_phase  = cpu8oar_pkg::PH_IDLE;
                    o_result = mk_final('0, 1'b0, i_item.program_counter);
                end else begin
                    n_pc     = i_item.program_counter + 16'd1;
                    n_phase  = cpu8oar_pkg::PH_OP1;
                    o_result = mk_read(i_item.program_counter);
                end
            end else begin
                unique case (r_phase)
                    cpu8oar_pkg::PH_OP1: begin
                        o_emit = 1'b1;
                        case (r_mode) inside
                            cpu8oar_pkg::M_IMMEDIATE, cpu8oar_pkg::M_ZP: begin
                                n_phase  = cpu8oar_pkg::PH_IDLE;
                                o_result = mk_final({8'd0, w_b}, 1'b0, r_pc);
                            end
                            cpu8oar_pkg::M_ZPX: begin
                                n_phase  = cpu8oar_pkg::PH_IDLE;
                                o_result = mk_final({8'd0, w_zp_x}, 1'b0, r_pc);
                            end
                            cpu8oar_pkg::M_ZPY: begin
                                n_phase  = cpu8oar_pkg::PH_IDLE;
                                o_result = mk_final({8'd0, w_zp_y}, 1'b0, r_pc);
                            end
                            cpu8oar_pkg::M_REL: begin
                                n_phase  = cpu8oar_pkg::PH_IDLE;
                                o_result = mk_final({{8{w_b[7]}}, w_b}, 1'b0, r_pc);
                            end
                            cpu8oar_pkg::M_IZX: begin
                                n_ptr    = {8'd0, w_zp_x};
                                n_phase  = cpu8oar_pkg::PH_PTRLO;
                                o_result = mk_read({8'd0, w_zp_x});
                            end
                            cpu8oar_pkg::M_IZY: begin
                                n_ptr    = {8'd0, w_b};
                                n_phase  = cpu8oar_pkg::PH_PTRLO;
                                o_result = mk_read({8'd0, w_b});
                            end
                            default: begin
                                n_first  = w_b;
                                n_pc     = r_pc + 16'd1;
                                n_phase  = cpu8oar_pkg::PH_OP2;
                                o_result = mk_read(r_pc);
                            end
                        endcase
                    end
                    cpu8oar_pkg::PH_OP2: begin
                        o_emit = 1'b1;
                        if (r_mode == cpu8oar_pkg::M_ABSX) begin
                            n_phase  = cpu8oar_pkg::PH_IDLE;
                            o_result = mk_final(w_sum_x, w_cross_x, r_pc);
                        end else if (r_mode == cpu8oar_pkg::M_ABSY) begin
                            n_phase  = cpu8oar_pkg::PH_IDLE;
                            o_result = mk_final(w_sum_y, w_cross_y, r_pc);
                        end else if (r_mode == cpu8oar_pkg::M_IND) begin
                            n_ptr    = w_word;
                            n_phase  = cpu8oar_pkg::PH_PTRLO;
                            o_result = mk_read(w_word);
                        end else begin
                            n_phase  = cpu8oar_pkg::PH_IDLE;
                            o_result = mk_final(w_word, 1'b0, r_pc);
                        end
                    end
                    cpu8oar_pkg::PH_PTRLO: begin
                        o_emit   = 1'b1;
                        n_first  = w_b;
                        n_phase  = cpu8oar_pkg::PH_PTRHI;
                        o_result = mk_read({r_ptr[15:8], r_ptr[7:0] + 8'd1});
                    end
                    cpu8oar_pkg::PH_PTRHI: begin
                        o_emit  = 1'b1;
                        n_phase = cpu8oar_pkg::PH_IDLE;
                        if (r_mode == cpu8oar_pkg::M_IZY) begin
                            o_result = mk_final(w_sum_y, w_cross_y, r_pc);
                        end else begin
                            o_result = mk_final(w_word, 1'b0, r_pc);
                        end
                    end
                    default: begin
                        n_phase = cpu8oar_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= cpu8oar_pkg::PH_IDLE;
            r_mode     <= cpu8oar_pkg::M_IMPLICIT;
            r_cross_en <= 1'b0;
            r_x        <= '0;
            r_y        <= '0;
            r_pc       <= '0;
            r_first    <= '0;
            r_ptr      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_cross_en <= n_cross_en;
            r_x        <= n_x;
            r_y        <= n_y;
            r_pc       <= n_pc;
            r_first    <= n_first;
            r_ptr      <= n_ptr;
        end
    end

endmodule

`default_nettype wire

/* src/cpu8oar_checker.sv */
// Port-level assertion checker for the operand address resolver, with its bind.
`default_nettype none
`include "cpu8_operand_address_resolver_defines.svh"

module cpu8oar_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_ready,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_kind,
    input wire [15:0] o_read_address,
    input wire [15:0] o_operand_value,
    input wire        o_page_crossed,
    input wire [15:0] o_next_pc
);

    logic        w_stall;
    logic [49:0] w_payload;
    logic        w_read_beat;
    logic        w_final_beat;
    logic        w_read_clean;
    logic        w_final_clean;

    assign w_stall       = o_out_valid && !i_out_ready;
    assign w_payload     = {o_kind, o_read_address, o_operand_value, o_page_crossed, o_next_pc};
    assign w_read_beat   = o_out_valid && (o_kind == cpu8oar_pkg::KIND_READ);
    assign w_final_beat  = o_out_valid && (o_kind == cpu8oar_pkg::KIND_FINAL);
    assign w_read_clean  = (o_operand_value == 16'd0) && !o_page_crossed && (o_next_pc == 16'd0);
    assign w_final_clean = (o_read_address == 16'd0);

    `CPU8OAR_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, w_stall, w_payload)
    `CPU8OAR_ASSERT_IMPLY(a_read_clean, i_clk, i_rst_n, w_read_beat, w_read_clean)
    `CPU8OAR_ASSERT_IMPLY(a_final_clean, i_clk, i_rst_n, w_final_beat, w_final_clean)
    `CPU8OAR_ASSERT_IMPLY(a_block_only_full, i_clk, i_rst_n, !o_in_ready, w_stall)

endmodule

bind cpu8_operand_address_resolver cpu8oar_checker u_checker (.*);

`default_nettype wire
